// File: rtl/date_time_difference_unit_defines.svh
// Assertion macros shared by the date-time difference checker.
`ifndef DATE_TIME_DIFFERENCE_UNIT_DEFINES_SVH
`define DATE_TIME_DIFFERENCE_UNIT_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define DTD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dtd check failed");

// Implication after a fixed number of cycles.
`define DTD_ASSERT_LAT(lbl, clk, rst_n, ante, cons, lat) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##(lat) (cons)) \
        else $error("dtd latency check failed");

`endif

// File: rtl/dtd_pkg.sv
// Package for the date-time difference unit: widths, constants and the month table.
`timescale 1ns / 1ps
package dtd_pkg;

    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int HOUR_W    = 5;
    localparam int MIN_W     = 6;
    localparam int SEC_W     = 6;
    localparam int DAYS_W    = 23;
    localparam int MD_W      = 9;
    localparam int MAXYEAR_W = 17;

    localparam int MAX_YEAR_DEF = 9999;

    localparam int MAX_HOUR     = 23;
    localparam int MAX_MIN_SEC  = 59;
    localparam int MIN_PER_HOUR = 60;
    localparam int HRS_PER_DAY  = 24;
    localparam int MONTHS       = 12;
    localparam int DAYS_PER_YR  = 365;
    localparam int CENTURY      = 100;

    // floor(y / 100) = (y * 5243) >> 19, exact for y below 43690
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_W     = 13;
    localparam int PROD_W      = YEAR_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    // input register to result strobe
    localparam int LATENCY = 5;

    // days in the year before the first of a month, index 0 is January
    function automatic logic [MD_W-1:0] month_start(input logic [MONTH_W-1:0] idx);
        logic [MD_W-1:0] v;
        case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/date_time_difference_unit.sv
// Top level of the date-time difference unit: A minus B in days, hours, minutes, seconds.
`timescale 1ns / 1ps
// Usage
//   Input channel: drive both date-times on the i_* field ports and raise start;
//   the item is taken at the rising edge where start is high and busy is low.
//   busy is held low, so an item may be offered in every cycle.
//   Result channel: o_valid strobes for one cycle with o_day_diff (signed),
//   o_hour_diff, o_minute_diff and o_second_diff. The receiver cannot hold
//   results off; one result per item, in the order items were taken.
//   Pipeline: five register stages lie between the accepting edge and o_valid
//   (clamp, year multiply and time borrow chain, leap count, day number,
//   day subtract). Throughput: one item per cycle.
//   Out-of-range fields are clamped (year to MAX_YEAR, month to 1..12,
//   hour to 23, minute and second to 59); day of month is not checked.
//   Reset (i_rst_n low, synchronous) clears the stage valid bits, so any
//   items in flight are dropped and no strobe follows until new items enter.
module date_time_difference_unit #(
    parameter int MAX_YEAR = dtd_pkg::MAX_YEAR_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [dtd_pkg::YEAR_W-1:0]        i_year_a,
    input  logic [dtd_pkg::MONTH_W-1:0]       i_month_a,
    input  logic [dtd_pkg::DAY_W-1:0]         i_day_a,
    input  logic [dtd_pkg::HOUR_W-1:0]        i_hour_a,
    input  logic [dtd_pkg::MIN_W-1:0]         i_minute_a,
    input  logic [dtd_pkg::SEC_W-1:0]         i_second_a,
    input  logic [dtd_pkg::YEAR_W-1:0]        i_year_b,
    input  logic [dtd_pkg::MONTH_W-1:0]       i_month_b,
    input  logic [dtd_pkg::DAY_W-1:0]         i_day_b,
    input  logic [dtd_pkg::HOUR_W-1:0]        i_hour_b,
    input  logic [dtd_pkg::MIN_W-1:0]         i_minute_b,
    input  logic [dtd_pkg::SEC_W-1:0]         i_second_b,
    output logic                              o_valid,
    output logic signed [dtd_pkg::DAYS_W-1:0] o_day_diff,
    output logic [dtd_pkg::HOUR_W-1:0]        o_hour_diff,
    output logic [dtd_pkg::MIN_W-1:0]         o_minute_diff,
    output logic [dtd_pkg::SEC_W-1:0]         o_second_diff
);

    localparam int YW = dtd_pkg::YEAR_W;
    localparam int MW = dtd_pkg::MONTH_W;
    localparam int DW = dtd_pkg::DAY_W;
    localparam int HW = dtd_pkg::HOUR_W;
    localparam int NW = dtd_pkg::MIN_W;
    localparam int SW = dtd_pkg::SEC_W;
    localparam int PW = dtd_pkg::PROD_W;
    localparam int QW = dtd_pkg::QUOT_W;
    localparam int TW = dtd_pkg::DAYS_W;
    localparam int KW = dtd_pkg::MD_W;

    localparam logic [dtd_pkg::MAXYEAR_W-1:0] MaxYearW = dtd_pkg::MAXYEAR_W'(MAX_YEAR);

    // ---------------- stage 1: clamp ----------------
    logic [4:0]    r_vld;
    logic [YW-1:0] r1_yr [2];
    logic [MW-1:0] r1_mi [2];
    logic [DW-1:0] r1_dy [2];
    logic [HW-1:0] r1_hr [2];
    logic [NW-1:0] r1_mn [2];
    logic [SW-1:0] r1_sc [2];

    logic [YW-1:0] w_yr [2];
    logic [MW-1:0] w_mo [2];
    logic [DW-1:0] w_dy [2];
    logic [HW-1:0] w_hr [2];
    logic [NW-1:0] w_mn [2];
    logic [SW-1:0] w_sc [2];

    logic [YW-1:0] n1_yr [2];
    logic [MW-1:0] n1_mi [2];
    logic [HW-1:0] n1_hr [2];
    logic [NW-1:0] n1_mn [2];
    logic [SW-1:0] n1_sc [2];

    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign w_yr[0] = i_year_a;   assign w_yr[1] = i_year_b;
    assign w_mo[0] = i_month_a;  assign w_mo[1] = i_month_b;
    assign w_dy[0] = i_day_a;    assign w_dy[1] = i_day_b;
    assign w_hr[0] = i_hour_a;   assign w_hr[1] = i_hour_b;
    assign w_mn[0] = i_minute_a; assign w_mn[1] = i_minute_b;
    assign w_sc[0] = i_second_a; assign w_sc[1] = i_second_b;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            n1_yr[i] = ({(dtd_pkg::MAXYEAR_W - YW)'(0), w_yr[i]} > MaxYearW)
                     ? MaxYearW[YW-1:0] : w_yr[i];
            // month kept as table index 0..11
            if (w_mo[i] == '0) begin
                n1_mi[i] = '0;
            end else if (w_mo[i] > MW'(dtd_pkg::MONTHS)) begin
                n1_mi[i] = MW'(dtd_pkg::MONTHS - 1);
            end else begin
                n1_mi[i] = w_mo[i] - MW'(1);
            end
            n1_hr[i] = (w_hr[i] > HW'(dtd_pkg::MAX_HOUR))    ? HW'(dtd_pkg::MAX_HOUR)    : w_hr[i];
            n1_mn[i] = (w_mn[i] > NW'(dtd_pkg::MAX_MIN_SEC)) ? NW'(dtd_pkg::MAX_MIN_SEC) : w_mn[i];
            n1_sc[i] = (w_sc[i] > SW'(dtd_pkg::MAX_MIN_SEC)) ? SW'(dtd_pkg::MAX_MIN_SEC) : w_sc[i];
        end
    end

    // ---------------- stage 2: year multiplies, month table, time borrow chain ----------------
    logic [YW-1:0] r2_yr   [2];
    logic [PW-1:0] r2_prod [2];
    logic [TW-1:0] r2_y365 [2];
    logic [KW-1:0] r2_md   [2];
    logic          r2_late [2];
    logic [HW-1:0] r2_hr;
    logic [NW-1:0] r2_mn;
    logic [SW-1:0] r2_sc;
    logic          r2_brw;

    logic [PW-1:0] n2_prod [2];
    logic [TW-1:0] n2_y365 [2];
    logic [KW-1:0] n2_md   [2];
    logic          n2_late [2];
    logic [SW:0]   w_ds;
    logic [NW:0]   w_dm;
    logic [HW:0]   w_dh;
    logic [HW-1:0] n2_hr;
    logic [NW-1:0] n2_mn;
    logic [SW-1:0] n2_sc;
    logic          n2_brw;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            n2_prod[i] = PW'(r1_yr[i]) * PW'(dtd_pkg::RECIP_100);
            n2_y365[i] = TW'(r1_yr[i]) * TW'(dtd_pkg::DAYS_PER_YR);
            n2_md[i]   = dtd_pkg::month_start(r1_mi[i]) + KW'(r1_dy[i]);
            n2_late[i] = (r1_mi[i] > MW'(1));
        end
        // mixed-radix subtract, borrow ripples seconds -> minutes -> hours -> days
        w_ds  = {1'b0, r1_sc[0]} - {1'b0, r1_sc[1]};
        n2_sc = w_ds[SW] ? SW'(w_ds + (SW+1)'(dtd_pkg::MIN_PER_HOUR)) : w_ds[SW-1:0];
        w_dm  = {1'b0, r1_mn[0]} - {1'b0, r1_mn[1]} - (NW+1)'(w_ds[SW]);
        n2_mn = w_dm[NW] ? NW'(w_dm + (NW+1)'(dtd_pkg::MIN_PER_HOUR)) : w_dm[NW-1:0];
        w_dh  = {1'b0, r1_hr[0]} - {1'b0, r1_hr[1]} - (HW+1)'(w_dm[NW]);
        n2_hr = w_dh[HW] ? HW'(w_dh + (HW+1)'(dtd_pkg::HRS_PER_DAY)) : w_dh[HW-1:0];
        n2_brw = w_dh[HW];
    end

    // ---------------- stage 3: leap count and leap-day adjust ----------------
    logic [TW-1:0] r3_base [2];
    logic [KW-1:0] r3_md   [2];
    logic [HW-1:0] r3_hr;
    logic [NW-1:0] r3_mn;
    logic [SW-1:0] r3_sc;
    logic          r3_brw;

    logic [QW-1:0] w_q    [2];
    logic [YW-1:0] w_q100 [2];
    logic          w_z100 [2];
    logic          w_z400 [2];
    logic          w_leap [2];
    logic [YW:0]   w_c4   [2];
    logic [TW-1:0] n3_base [2];
    logic [KW-1:0] n3_md   [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            w_q[i]    = r2_prod[i][PW-1:dtd_pkg::RECIP_SHIFT];
            w_q100[i] = YW'(w_q[i]) * YW'(dtd_pkg::CENTURY);
            w_z100[i] = (r2_yr[i] == w_q100[i]);
            w_z400[i] = w_z100[i] && (w_q[i][1:0] == 2'b00);
            w_leap[i] = ((r2_yr[i][1:0] == 2'b00) && !w_z100[i]) || w_z400[i];
            w_c4[i]   = ({1'b0, r2_yr[i]} + (YW+1)'(3)) >> 2;
            // leap years before y: ceil(y/4) - ceil(y/100) + ceil(y/400)
            n3_base[i] = r2_y365[i] + TW'(w_c4[i]) - TW'(w_q[i]) - TW'(!w_z100[i])
                       + TW'(w_q[i] >> 2) + TW'(!w_z400[i]);
            n3_md[i]   = r2_md[i] + KW'(w_leap[i] && r2_late[i]);
        end
    end

    // ---------------- stage 4: day numbers ----------------
    logic [TW-1:0] r4_dn [2];
    logic [HW-1:0] r4_hr;
    logic [NW-1:0] r4_mn;
    logic [SW-1:0] r4_sc;
    logic          r4_brw;

    logic [TW-1:0] n4_dn [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            n4_dn[i] = r3_base[i] + TW'(r3_md[i]);
        end
    end

    // ---------------- stage 5: day difference with borrow ----------------
    logic [TW-1:0] r5_days;
    logic [HW-1:0] r5_hr;
    logic [NW-1:0] r5_mn;
    logic [SW-1:0] r5_sc;

    logic [TW:0]   w_diff;
    logic [TW-1:0] n5_days;

    always_comb begin
        w_diff  = {1'b0, r4_dn[0]} - {1'b0, r4_dn[1]} - (TW+1)'(r4_brw);
        n5_days = w_diff[TW-1:0];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], accept};
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 2; i++) begin
            r1_yr[i]   <= n1_yr[i];
            r1_mi[i]   <= n1_mi[i];
            r1_dy[i]   <= w_dy[i];
            r1_hr[i]   <= n1_hr[i];
            r1_mn[i]   <= n1_mn[i];
            r1_sc[i]   <= n1_sc[i];
            r2_yr[i]   <= r1_yr[i];
            r2_prod[i] <= n2_prod[i];
            r2_y365[i] <= n2_y365[i];
            r2_md[i]   <= n2_md[i];
            r2_late[i] <= n2_late[i];
            r3_base[i] <= n3_base[i];
            r3_md[i]   <= n3_md[i];
            r4_dn[i]   <= n4_dn[i];
        end
        r2_hr   <= n2_hr;
        r2_mn   <= n2_mn;
        r2_sc   <= n2_sc;
        r2_brw  <= n2_brw;
        r3_hr   <= r2_hr;
        r3_mn   <= r2_mn;
        r3_sc   <= r2_sc;
        r3_brw  <= r2_brw;
        r4_hr   <= r3_hr;
        r4_mn   <= r3_mn;
        r4_sc   <= r3_sc;
        r4_brw  <= r3_brw;
        r5_days <= n5_days;
        r5_hr   <= r4_hr;
        r5_mn   <= r4_mn;
        r5_sc   <= r4_sc;
    end

    assign o_valid       = r_vld[4];
    assign o_day_diff    = signed'(r5_days);
    assign o_hour_diff   = r5_hr;
    assign o_minute_diff = r5_mn;
    assign o_second_diff = r5_sc;

endmodule

// File: rtl/dtd_chk.sv
// Port checker for the date-time difference unit, bound to the top level.
`timescale 1ns / 1ps
`include "date_time_difference_unit_defines.svh"

module dtd_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_valid,
    input logic [dtd_pkg::HOUR_W-1:0] o_hour_diff,
    input logic [dtd_pkg::MIN_W-1:0]  o_minute_diff,
    input logic [dtd_pkg::SEC_W-1:0]  o_second_diff
);

    logic w_tod_ok;

    assign w_tod_ok = (o_hour_diff <= dtd_pkg::HOUR_W'(dtd_pkg::MAX_HOUR))
                   && (o_minute_diff <= dtd_pkg::MIN_W'(dtd_pkg::MAX_MIN_SEC))
                   && (o_second_diff <= dtd_pkg::SEC_W'(dtd_pkg::MAX_MIN_SEC));

    // every item taken gives a strobe after the fixed latency
    `DTD_ASSERT_LAT(a_item_latency, i_clk, i_rst_n, start && !busy, o_valid, dtd_pkg::LATENCY)

    // no strobe without an item taken the latency earlier
    `DTD_ASSERT_IMPL(a_no_spurious, i_clk, i_rst_n, o_valid, $past(start && !busy, dtd_pkg::LATENCY))

    // remainder after the day borrow always lies within one day
    `DTD_ASSERT_IMPL(a_tod_range, i_clk, i_rst_n, o_valid, w_tod_ok)

endmodule

bind date_time_difference_unit dtd_chk u_dtd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_hour_diff   (o_hour_diff),
    .o_minute_diff (o_minute_diff),
    .o_second_diff (o_second_diff)
);

// File: tb/sv/tb_top.sv
// Self-checking bench for the date-time difference unit: bursty stimulus, in-order result check.
`timescale 1ns / 1ps
module tb_top;

    localparam int YEAR_CAP       = dtd_pkg::MAX_YEAR_DEF;
    localparam int RANDOM_ITEMS   = 1130;
    localparam int IDLE_LIMIT     = 2000;
    localparam int SECS_PER_DAY   = 86400;
    localparam int SECS_PER_HOUR  = 3600;

    typedef struct packed {
        logic [dtd_pkg::YEAR_W-1:0]  year;
        logic [dtd_pkg::MONTH_W-1:0] month;
        logic [dtd_pkg::DAY_W-1:0]   day;
        logic [dtd_pkg::HOUR_W-1:0]  hour;
        logic [dtd_pkg::MIN_W-1:0]   minute;
        logic [dtd_pkg::SEC_W-1:0]   second;
    } t_stamp;

    typedef struct packed {
        logic signed [dtd_pkg::DAYS_W-1:0] days;
        logic [dtd_pkg::HOUR_W-1:0]        hours;
        logic [dtd_pkg::MIN_W-1:0]         minutes;
        logic [dtd_pkg::SEC_W-1:0]         seconds;
    } t_span;

    // Works out A minus B for each accepted item and holds the spans still due.
    class span_scoreboard;
        t_span       due_spans[$];
        int          errors;
        int unsigned days_before_month[12] =
            '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

        function automatic bit is_leap(int unsigned y);
            return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        endfunction

        function automatic int day_index(t_stamp s);
            int unsigned y;
            int unsigned m;
            int unsigned n;
            y = s.year;
            m = s.month;
            if (y > YEAR_CAP) y = YEAR_CAP;
            if (m < 1) m = 1;
            if (m > dtd_pkg::MONTHS) m = dtd_pkg::MONTHS;
            n = dtd_pkg::DAYS_PER_YR * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
            n += days_before_month[m - 1];
            if (m > 2 && is_leap(y)) n += 1;
            return int'(n + s.day);
        endfunction

        function automatic int clock_secs(t_stamp s);
            int h;
            int mi;
            int sc;
            h  = (s.hour > dtd_pkg::MAX_HOUR) ? dtd_pkg::MAX_HOUR : int'(s.hour);
            mi = (s.minute > dtd_pkg::MAX_MIN_SEC) ? dtd_pkg::MAX_MIN_SEC : int'(s.minute);
            sc = (s.second > dtd_pkg::MAX_MIN_SEC) ? dtd_pkg::MAX_MIN_SEC : int'(s.second);
            return h * SECS_PER_HOUR + mi * dtd_pkg::MIN_PER_HOUR + sc;
        endfunction

        function void note_item(t_stamp a, t_stamp b);
            int    d;
            int    t;
            t_span exp_span;
            d = day_index(a) - day_index(b);
            t = clock_secs(a) - clock_secs(b);
            // negative time of day borrows a whole day
            if (t < 0) begin
                d -= 1;
                t += SECS_PER_DAY;
            end
            exp_span.days    = d[dtd_pkg::DAYS_W-1:0];
            exp_span.hours   = dtd_pkg::HOUR_W'(t / SECS_PER_HOUR);
            exp_span.minutes = dtd_pkg::MIN_W'((t % SECS_PER_HOUR) / dtd_pkg::MIN_PER_HOUR);
            exp_span.seconds = dtd_pkg::SEC_W'(t % dtd_pkg::MIN_PER_HOUR);
            due_spans.push_back(exp_span);
        endfunction

        function void report(string what, int exp_v, int got_v);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, what, exp_v, got_v);
        endfunction

        function void check_span(t_span got);
            t_span exp_span;
            if (due_spans.size() == 0) begin
                errors++;
                $display("%0t: result with nothing due, expected none, actual %0d",
                         $time, got.days);
                return;
            end
            exp_span = due_spans.pop_front();
            if (got.days !== exp_span.days)
                report("day_diff", int'(exp_span.days), int'(got.days));
            if (got.hours !== exp_span.hours)
                report("hour_diff", int'(exp_span.hours), int'(got.hours));
            if (got.minutes !== exp_span.minutes)
                report("minute_diff", int'(exp_span.minutes), int'(got.minutes));
            if (got.seconds !== exp_span.seconds)
                report("second_diff", int'(exp_span.seconds), int'(got.seconds));
        endfunction

        function int pending();
            return due_spans.size();
        endfunction
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              start;
    logic                              busy;
    logic [dtd_pkg::YEAR_W-1:0]        i_year_a, i_year_b;
    logic [dtd_pkg::MONTH_W-1:0]       i_month_a, i_month_b;
    logic [dtd_pkg::DAY_W-1:0]         i_day_a, i_day_b;
    logic [dtd_pkg::HOUR_W-1:0]        i_hour_a, i_hour_b;
    logic [dtd_pkg::MIN_W-1:0]         i_minute_a, i_minute_b;
    logic [dtd_pkg::SEC_W-1:0]         i_second_a, i_second_b;
    logic                              o_valid;
    logic signed [dtd_pkg::DAYS_W-1:0] o_day_diff;
    logic [dtd_pkg::HOUR_W-1:0]        o_hour_diff;
    logic [dtd_pkg::MIN_W-1:0]         o_minute_diff;
    logic [dtd_pkg::SEC_W-1:0]         o_second_diff;

    span_scoreboard sb;
    int             idle_cycles;

    date_time_difference_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_year_a      (i_year_a),
        .i_month_a     (i_month_a),
        .i_day_a       (i_day_a),
        .i_hour_a      (i_hour_a),
        .i_minute_a    (i_minute_a),
        .i_second_a    (i_second_a),
        .i_year_b      (i_year_b),
        .i_month_b     (i_month_b),
        .i_day_b       (i_day_b),
        .i_hour_b      (i_hour_b),
        .i_minute_b    (i_minute_b),
        .i_second_b    (i_second_b),
        .o_valid       (o_valid),
        .o_day_diff    (o_day_diff),
        .o_hour_diff   (o_hour_diff),
        .o_minute_diff (o_minute_diff),
        .o_second_diff (o_second_diff)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_stamp mk(int y, int m, int d, int h, int mi, int s);
        t_stamp st;
        st.year   = dtd_pkg::YEAR_W'(y);
        st.month  = dtd_pkg::MONTH_W'(m);
        st.day    = dtd_pkg::DAY_W'(d);
        st.hour   = dtd_pkg::HOUR_W'(h);
        st.minute = dtd_pkg::MIN_W'(mi);
        st.second = dtd_pkg::SEC_W'(s);
        return st;
    endfunction

    // Mostly legal fields; now and then a field takes any value of its width.
    function automatic t_stamp random_stamp();
        t_stamp st;
        st.year   = ($urandom_range(0, 9) == 0) ? dtd_pkg::YEAR_W'($urandom)
                  : dtd_pkg::YEAR_W'($urandom_range(0, YEAR_CAP));
        st.month  = ($urandom_range(0, 9) == 0) ? dtd_pkg::MONTH_W'($urandom)
                  : dtd_pkg::MONTH_W'($urandom_range(1, dtd_pkg::MONTHS));
        st.day    = ($urandom_range(0, 9) == 0) ? dtd_pkg::DAY_W'($urandom)
                  : dtd_pkg::DAY_W'($urandom_range(1, 31));
        st.hour   = ($urandom_range(0, 9) == 0) ? dtd_pkg::HOUR_W'($urandom)
                  : dtd_pkg::HOUR_W'($urandom_range(0, dtd_pkg::MAX_HOUR));
        st.minute = ($urandom_range(0, 9) == 0) ? dtd_pkg::MIN_W'($urandom)
                  : dtd_pkg::MIN_W'($urandom_range(0, dtd_pkg::MAX_MIN_SEC));
        st.second = ($urandom_range(0, 9) == 0) ? dtd_pkg::SEC_W'($urandom)
                  : dtd_pkg::SEC_W'($urandom_range(0, dtd_pkg::MAX_MIN_SEC));
        return st;
    endfunction

    // Called at a rising edge; returns at the edge that takes the item.
    task automatic send_pair(t_stamp a, t_stamp b);
        start      <= 1'b1;
        i_year_a   <= a.year;
        i_month_a  <= a.month;
        i_day_a    <= a.day;
        i_hour_a   <= a.hour;
        i_minute_a <= a.minute;
        i_second_a <= a.second;
        i_year_b   <= b.year;
        i_month_b  <= b.month;
        i_day_b    <= b.day;
        i_hour_b   <= b.hour;
        i_minute_b <= b.minute;
        i_second_b <= b.second;
        do @(posedge i_clk); while (busy);
        sb.note_item(a, b);
    endtask

    task automatic idle_for(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // result check and stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_span('{o_day_diff, o_hour_diff, o_minute_diff, o_second_diff});
        if (!i_rst_n || o_valid || (start && !busy)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_stamp a;
        t_stamp b;
        int     sent;
        int     burst;
        sb          = new();
        idle_cycles = 0;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_year_a   <= '0;
        i_month_a  <= '0;
        i_day_a    <= '0;
        i_hour_a   <= '0;
        i_minute_a <= '0;
        i_second_a <= '0;
        i_year_b   <= '0;
        i_month_b  <= '0;
        i_day_b    <= '0;
        i_hour_b   <= '0;
        i_minute_b <= '0;
        i_second_b <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_pair(mk(0, 1, 1, 0, 0, 0), mk(0, 1, 1, 0, 0, 0));
        send_pair(mk(9999, 12, 31, 23, 59, 59), mk(0, 1, 1, 0, 0, 0));
        send_pair(mk(0, 1, 1, 0, 0, 0), mk(9999, 12, 31, 23, 59, 59));
        send_pair(mk(16383, 15, 31, 31, 63, 63), mk(0, 0, 0, 0, 0, 0));
        send_pair(mk(0, 0, 0, 0, 0, 0), mk(16383, 15, 31, 31, 63, 63));
        send_pair(mk(2000, 3, 1, 0, 0, 0), mk(2000, 2, 28, 0, 0, 0));
        send_pair(mk(1900, 3, 1, 0, 0, 0), mk(1900, 2, 28, 0, 0, 0));
        send_pair(mk(0, 3, 1, 12, 0, 0), mk(0, 2, 28, 12, 0, 0));
        send_pair(mk(2024, 3, 1, 0, 0, 0), mk(2023, 3, 1, 0, 0, 0));
        // time of day behind: borrow a day
        send_pair(mk(2024, 5, 10, 1, 0, 0), mk(2024, 5, 9, 23, 59, 59));
        send_pair(mk(2024, 5, 10, 0, 0, 0), mk(2024, 5, 10, 0, 0, 1));
        send_pair(mk(100, 0, 15, 5, 6, 7), mk(100, 1, 15, 5, 6, 7));
        send_pair(mk(100, 14, 1, 0, 0, 0), mk(100, 12, 1, 0, 0, 0));
        // day beyond the month and day zero
        send_pair(mk(2023, 2, 31, 0, 0, 0), mk(2023, 3, 0, 0, 0, 0));
        send_pair(mk(10000, 1, 1, 0, 0, 0), mk(9999, 1, 1, 0, 0, 0));
        send_pair(mk(400, 12, 31, 24, 60, 60), mk(400, 12, 31, 23, 59, 59));
        send_pair(mk(1, 1, 1, 0, 0, 0), mk(0, 12, 31, 23, 59, 59));
        send_pair(mk(8191, 8, 16, 16, 32, 32), mk(5461, 5, 21, 21, 42, 21));
        send_pair(mk(2047, 7, 15, 15, 31, 31), mk(4096, 9, 10, 10, 10, 42));
        idle_for(3);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < RANDOM_ITEMS) begin
                a = random_stamp();
                b = random_stamp();
                // close pairs exercise small spans and the borrow
                if ($urandom_range(0, 3) == 0) begin
                    b.year  = a.year;
                    b.month = a.month;
                    if ($urandom_range(0, 1) == 0) b.day = a.day;
                end
                send_pair(a, b);
                sent++;
                burst--;
            end
            if ($urandom_range(0, 2) != 0)
                idle_for($urandom_range(1, 8));
        end
        idle_for(1);

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (dtd_pkg::LATENCY + 4) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl
rtl/dtd_pkg.sv
rtl/date_time_difference_unit.sv
rtl/dtd_chk.sv
tb/sv/tb_top.sv
